@@ hw/rtl/stable_priority_task_queue_top_macros.svh @@
// Assertion macros for the stable priority task queue.
// Included by modules that check their own logic; needs clk_i and rst_ni in scope.
`ifndef STABLE_PRIORITY_TASK_QUEUE_TOP_MACROS_SVH
`define STABLE_PRIORITY_TASK_QUEUE_TOP_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition leads to a consequence in the cycle after it.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/spq_pkg.sv @@
// Shared types and constants of the stable priority task queue.
// Used by spq_cell and stable_priority_task_queue_top; depends on nothing.
package spq_pkg;

  localparam int DefaultDepth = 16;
  localparam int IdW = 16;
  localparam int PrioW = 8;
  localparam int TimeW = 16;
  localparam int OccW = 5;

  localparam logic FuncInsert = 1'b0;
  localparam logic FuncPop = 1'b1;

  typedef enum logic [1:0] {
    StInserted = 2'd0,
    StPopped = 2'd1,
    StEmpty = 2'd2,
    StFull = 2'd3
  } status_e;

  typedef struct packed {
    logic [IdW-1:0] id;
    logic [PrioW-1:0] prio;
    logic [TimeW-1:0] etime;
  } task_t;

  typedef struct packed {
    logic ins;
    logic pop;
    task_t new_task;
  } cell_ctrl_t;

endpackage

@@ hw/rtl/spq_cell.sv @@
// One cell of the sorted task chain: holds one task and compares it with a new one.
// Depends on spq_pkg for the task and control types.
module spq_cell #(
  parameter int Idx = 0,
  parameter int CntW = 5
) (
  input  logic               clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  logic [CntW-1:0]    count_i,
  input  logic               prev_ge_i,
  input  spq_pkg::task_t     prev_task_i,
  input  spq_pkg::task_t     next_task_i,
  output logic               ge_o,
  output spq_pkg::task_t     task_o
);
  import spq_pkg::*;

  task_t task_q;
  task_t task_d;
  logic  valid;

  assign valid = count_i > CntW'(Idx);
  assign ge_o = valid && (task_q.prio >= ctrl_i.new_task.prio);
  assign task_o = task_q;

  always_comb begin
    task_d = task_q;
    if (ctrl_i.ins) begin
      if (!ge_o) begin
        task_d = prev_ge_i ? ctrl_i.new_task : prev_task_i;
      end
    end else if (ctrl_i.pop) begin
      task_d = next_task_i;
    end
  end

  always_ff @(posedge clk_i) begin
    task_q <= task_d;
  end

endmodule

@@ hw/rtl/stable_priority_task_queue_top.sv @@
// Top level of the stable priority task queue: a chain of spq_cell stages and an output register.
// Depends on spq_pkg, spq_cell and stable_priority_task_queue_top_macros.svh.
//
// Usage: an input item carries func_i (insert or pop) and the task fields. It is accepted
// at a rising edge with in_valid_i high and in_stall_o low. Every item yields exactly one
// result item on the output channel, taken at an edge with out_valid_o high and
// out_stall_i low. An insert places the task behind all stored tasks of equal or higher
// priority; a pop returns the head task. A full insert reports status 3, an empty pop 2.
// Latency: the result appears in the cycle after acceptance. Throughput: one item per
// cycle unless the output stalls, set by the compare and shift all cells do in parallel.
// While a result waits and out_stall_i is high, in_stall_o is high and no item is taken;
// a taken result frees the input in the same cycle.
// Reset clears the task count and the output valid; the store is empty after reset and
// needs no clearing pass.
module stable_priority_task_queue_top #(
  parameter int Depth = spq_pkg::DefaultDepth
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     func_i,
  input  logic [spq_pkg::IdW-1:0]  task_id_i,
  input  logic [spq_pkg::PrioW-1:0] task_priority_i,
  input  logic [spq_pkg::TimeW-1:0] exec_time_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               status_o,
  output logic [spq_pkg::IdW-1:0]  out_task_id_o,
  output logic [spq_pkg::PrioW-1:0] out_priority_o,
  output logic [spq_pkg::TimeW-1:0] out_exec_time_o,
  output logic [spq_pkg::OccW-1:0] occupancy_o
);
  import spq_pkg::*;
  `include "stable_priority_task_queue_top_macros.svh"

  localparam int CntW = $clog2(Depth + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  status_e         status_q, status_d;
  task_t           res_q, res_d;
  logic [OccW-1:0] occ_q;

  logic       acc, full, empty;
  cell_ctrl_t ctrl;
  logic       ge_w [Depth];
  task_t      task_w [Depth];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign acc = in_valid_i && !in_stall_o;
  assign full = count_q == CntW'(Depth);
  assign empty = count_q == '0;

  assign ctrl.new_task.id = task_id_i;
  assign ctrl.new_task.prio = task_priority_i;
  assign ctrl.new_task.etime = exec_time_i;
  assign ctrl.ins = acc && (func_i == FuncInsert) && !full;
  assign ctrl.pop = acc && (func_i == FuncPop) && !empty;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic  prev_ge;
    task_t prev_task, next_task;
    if (i == 0) begin : g_first
      assign prev_ge = 1'b1;
      assign prev_task = ctrl.new_task;
    end else begin : g_mid
      assign prev_ge = ge_w[i-1];
      assign prev_task = task_w[i-1];
    end
    if (i == Depth - 1) begin : g_last
      assign next_task = task_w[i];
    end else begin : g_inner
      assign next_task = task_w[i+1];
    end
    spq_cell #(
      .Idx (i),
      .CntW(CntW)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .count_i    (count_q),
      .prev_ge_i  (prev_ge),
      .prev_task_i(prev_task),
      .next_task_i(next_task),
      .ge_o       (ge_w[i]),
      .task_o     (task_w[i])
    );
  end

  always_comb begin
    count_d = count_q;
    res_d = '0;
    unique case (func_i)
      FuncInsert: begin
        status_d = full ? StFull : StInserted;
        if (!full) begin
          count_d = count_q + CntW'(1);
        end
      end
      FuncPop: begin
        status_d = empty ? StEmpty : StPopped;
        if (!empty) begin
          count_d = count_q - CntW'(1);
          res_d = task_w[0];
        end
      end
      default: begin
        status_d = StEmpty;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        count_q <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      status_q <= status_d;
      res_q <= res_d;
      occ_q <= OccW'(count_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o = status_q;
  assign out_task_id_o = res_q.id;
  assign out_priority_o = res_q.prio;
  assign out_exec_time_o = res_q.etime;
  assign occupancy_o = occ_q;

  `SPQ_ASSERT(a_count_bound, count_q <= CntW'(Depth), "Task count exceeds depth.")
  `SPQ_ASSERT(a_head_sorted, (count_q < CntW'(2)) || (task_w[0].prio >= task_w[1].prio),
              "Head task is not of the highest priority.")
  `SPQ_ASSERT_NEXT(a_pop_empty, acc && (func_i == FuncPop) && empty,
                   (count_q == '0) && (status_q == StEmpty), "Pop on empty changed the count.")
  `SPQ_ASSERT_NEXT(a_insert_count, ctrl.ins, count_q == $past(count_q) + CntW'(1),
                   "Insert did not raise the count by one.")
  `SPQ_ASSERT_NEXT(a_result_follows, acc, out_valid_o, "Accepted item produced no result.")

endmodule
